### src/profile_sweep_vertex_gen_assert.svh
// ----------------------------------------------------------------------------
// profile_sweep_vertex_gen_assert
// Assertion macros used by the checker file psv_checker.
// ----------------------------------------------------------------------------
`ifndef PROFILE_SWEEP_VERTEX_GEN_ASSERT_SVH
`define PROFILE_SWEEP_VERTEX_GEN_ASSERT_SVH

// Checked outside reset.
`define PSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and constants of the profile sweep vertex generator.
// ----------------------------------------------------------------------------
package psv_pkg;

  localparam int PROFILE_MAX_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int COL_W           = 5;
  localparam int ROW_W           = 16;

  localparam logic signed [15:0] Q15_ONE = 16'sd32767;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_SEED  = 2'd2,
    ACT_PATH  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            act;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  // tangent unit request: magnitudes already range-reduced to 31 bits
  typedef struct packed {
    logic        start;
    logic [30:0] mag_a;
    logic [30:0] mag_b;
    logic        neg_x;
    logic        neg_y;
  } tan_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
  } tan_rsp_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQUARE,
    T_SUM,
    T_ROOT,
    T_DSETUP,
    T_DIV
  } tan_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TAN,
    B_ROWS,
    B_DRAIN
  } back_state_t;

  // per-vertex tag traveling down the vertex pipeline
  typedef struct packed {
    logic [32:0]      bx;
    logic [32:0]      by;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } vmeta_t;

endpackage

### src/psv_front.sv
// ----------------------------------------------------------------------------
// psv_front
// Input side: classifies items and holds them in a short queue.
// ----------------------------------------------------------------------------
module psv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               q_valid,
  output psv_pkg::item_t     q_item,
  input  logic               q_pop
);

  localparam int PW = $clog2(psv_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(psv_pkg::QUEUE_DEPTH + 1);

  psv_pkg::item_t q_mem_r [psv_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic           push;
  psv_pkg::item_t item_in;

  always_comb begin
    item_in.act = psv_pkg::action_t'(in_action);
    item_in.x   = in_point_x;
    item_in.y   = in_point_y;
  end

  assign in_stall = (cnt_r == CW'(psv_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + CW'(push) - CW'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)  wr_ptr_r <= wr_ptr_r + PW'(1);
      if (q_pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item_in;
  end

endmodule

### src/psv_tangent.sv
// ----------------------------------------------------------------------------
// psv_tangent
// Unit tangent: squares, bit-pair square root, two restoring dividers.
// ----------------------------------------------------------------------------
module psv_tangent (
  input  logic              clk,
  input  logic              rst_n,
  input  psv_pkg::tan_req_t req,
  output psv_pkg::tan_rsp_t rsp
);

  localparam int QW = 17;  // quotient bits, value never above 32768

  psv_pkg::tan_state_t st_r, st_nxt;

  logic [30:0]        a_r, b_r;
  logic               negx_r, negy_r;
  logic [61:0]        sqa_r, sqb_r;
  logic [63:0]        n_r, r_r, bit_r;
  logic [16:0]        low_a_r, low_b_r;
  logic [31:0]        rem_a_r, rem_b_r;
  logic [QW-1:0]      qa_r, qb_r;
  logic [4:0]         step_r;
  logic               done_r;
  logic signed [15:0] tx_r, ty_r;

  logic [63:0] trial;
  logic        root_ge;
  logic [47:0] num_a, num_b;
  logic [32:0] len33, ta, tb;
  logic        ge_a, ge_b;
  logic [QW-1:0] qa_f, qb_f;
  logic [14:0] mag_x, mag_y;

  assign trial   = r_r + bit_r;
  assign root_ge = (n_r >= trial);
  assign num_a   = {2'b00, a_r, 15'd0} + {17'd0, r_r[31:1]};
  assign num_b   = {2'b00, b_r, 15'd0} + {17'd0, r_r[31:1]};
  assign len33   = {1'b0, r_r[31:0]};
  assign ta      = {rem_a_r, low_a_r[16]};
  assign tb      = {rem_b_r, low_b_r[16]};
  assign ge_a    = (ta >= len33);
  assign ge_b    = (tb >= len33);
  assign qa_f    = {qa_r[QW-2:0], ge_a};
  assign qb_f    = {qb_r[QW-2:0], ge_b};
  assign mag_x   = (qa_f > QW'(32767)) ? 15'h7fff : qa_f[14:0];
  assign mag_y   = (qb_f > QW'(32767)) ? 15'h7fff : qb_f[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= psv_pkg::T_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      psv_pkg::T_IDLE:   if (req.start) st_nxt = psv_pkg::T_SQUARE;
      psv_pkg::T_SQUARE: st_nxt = psv_pkg::T_SUM;
      psv_pkg::T_SUM:    st_nxt = psv_pkg::T_ROOT;
      psv_pkg::T_ROOT:   if (bit_r[0]) st_nxt = psv_pkg::T_DSETUP;
      psv_pkg::T_DSETUP: st_nxt = psv_pkg::T_DIV;
      psv_pkg::T_DIV:    if (step_r == 5'(QW - 1)) st_nxt = psv_pkg::T_IDLE;
      default:           st_nxt = psv_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == psv_pkg::T_DIV) && (step_r == 5'(QW - 1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      psv_pkg::T_IDLE: begin
        if (req.start) begin
          a_r    <= req.mag_a;
          b_r    <= req.mag_b;
          negx_r <= req.neg_x;
          negy_r <= req.neg_y;
        end
      end
      psv_pkg::T_SQUARE: begin
        sqa_r <= a_r * a_r;
        sqb_r <= b_r * b_r;
      end
      psv_pkg::T_SUM: begin
        n_r   <= {2'b00, sqa_r} + {2'b00, sqb_r};
        r_r   <= '0;
        bit_r <= 64'd1 << 62;
      end
      psv_pkg::T_ROOT: begin
        if (root_ge) begin
          n_r <= n_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      psv_pkg::T_DSETUP: begin
        rem_a_r <= {1'b0, num_a[47:17]};
        rem_b_r <= {1'b0, num_b[47:17]};
        low_a_r <= num_a[16:0];
        low_b_r <= num_b[16:0];
        qa_r    <= '0;
        qb_r    <= '0;
        step_r  <= '0;
      end
      psv_pkg::T_DIV: begin
        rem_a_r <= ge_a ? 32'(ta - len33) : ta[31:0];
        rem_b_r <= ge_b ? 32'(tb - len33) : tb[31:0];
        low_a_r <= {low_a_r[15:0], 1'b0};
        low_b_r <= {low_b_r[15:0], 1'b0};
        qa_r    <= qa_f;
        qb_r    <= qb_f;
        step_r  <= step_r + 5'd1;
        if (step_r == 5'(QW - 1)) begin
          tx_r <= negx_r ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
          ty_r <= negy_r ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.tx   = tx_r;
  assign rsp.ty   = ty_r;

endmodule

### src/psv_back.sv
// ----------------------------------------------------------------------------
// psv_back
// Executes queued items: path state, profile store, vertex pipeline.
// ----------------------------------------------------------------------------
module psv_back #(
  parameter int PROFILE_MAX = psv_pkg::PROFILE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  psv_pkg::item_t     q_item,
  output logic               q_pop,
  output psv_pkg::tan_req_t  tan_req,
  input  psv_pkg::tan_rsp_t  tan_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z,
  output logic [15:0]        out_row_number,
  output logic [4:0]         out_column_number,
  output logic               out_last_of_run
);

  localparam int IW = (PROFILE_MAX > 1) ? $clog2(PROFILE_MAX) : 1;
  localparam int NW = $clog2(PROFILE_MAX + 1);

  psv_pkg::back_state_t st_r, st_nxt;

  logic signed [31:0] store_x [PROFILE_MAX];
  logic signed [31:0] store_y [PROFILE_MAX];

  logic [NW-1:0]      cnt_r;
  logic signed [31:0] prev_x_r, prev_y_r, org_x_r, org_y_r;
  logic               have_prev_r, org_known_r, first_pend_r;
  logic signed [15:0] tx_r, ty_r;
  logic [15:0]        row_r;
  logic [IW-1:0]      col_r;
  logic               two_rows_r, on_first_r;
  logic [32:0]        bp_x_r, bp_y_r, bc_x_r, bc_y_r;

  // vertex pipeline
  logic               s1_v_r, s2_v_r;
  logic signed [31:0] s1_rx_r, s1_ry_r, s2_z_r;
  psv_pkg::vmeta_t    s1_m_r, s2_m_r;
  logic signed [47:0] pty_r, ptx_r;
  logic               out_v_r;
  logic [31:0]        ox_r, oy_r, oz_r;
  logic [15:0]        orow_r;
  logic [4:0]         ocol_r;
  logic               olast_r;

  logic               en, take, is_path_go, zero_step, row_done, last_row, issue;
  logic signed [31:0] org_x_n, org_y_n;
  logic [32:0]        dx, dy, ax, ay;
  logic               halve;
  psv_pkg::vmeta_t    meta_in;
  logic signed [48:0] rnd_x, rnd_y, shx, shy;
  logic [34:0]        sum_x, sum_y;

  function automatic logic [31:0] sat35(input logic [34:0] v);
    logic [31:0] res;
    if (!v[34] && (v[33:31] != 3'b000))      res = 32'h7fff_ffff;
    else if (v[34] && (v[33:31] != 3'b111))  res = 32'h8000_0000;
    else                                     res = v[31:0];
    return res;
  endfunction

  assign en    = !out_v_r || !out_stall;
  assign take  = (st_r == psv_pkg::B_IDLE) && q_valid;
  assign q_pop = take;

  assign org_x_n = org_known_r ? org_x_r : q_item.x;
  assign org_y_n = org_known_r ? org_y_r : q_item.y;
  assign dx      = {q_item.x[31], q_item.x} - {prev_x_r[31], prev_x_r};
  assign dy      = {q_item.y[31], q_item.y} - {prev_y_r[31], prev_y_r};
  assign ax      = dx[32] ? (33'd0 - dx) : dx;
  assign ay      = dy[32] ? (33'd0 - dy) : dy;
  assign halve   = ax[32] || ax[31] || ay[32] || ay[31];
  assign zero_step  = (dx == '0) && (dy == '0);
  assign is_path_go = take && (q_item.act == psv_pkg::ACT_PATH) && have_prev_r;

  assign tan_req.start = is_path_go && !zero_step;
  assign tan_req.mag_a = halve ? ax[31:1] : ax[30:0];
  assign tan_req.mag_b = halve ? ay[31:1] : ay[30:0];
  assign tan_req.neg_x = dx[32];
  assign tan_req.neg_y = dy[32];

  assign row_done = (cnt_r == '0) || (NW'(col_r) == cnt_r - NW'(1));
  assign last_row = !(two_rows_r && on_first_r);
  assign issue    = (st_r == psv_pkg::B_ROWS) && en && (cnt_r != '0);

  always_comb begin
    meta_in.bx   = on_first_r ? bp_x_r : bc_x_r;
    meta_in.by   = on_first_r ? bp_y_r : bc_y_r;
    meta_in.row  = row_r;
    meta_in.col  = psv_pkg::COL_W'(col_r);
    meta_in.last = row_done && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= psv_pkg::B_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      psv_pkg::B_IDLE:  if (is_path_go) st_nxt = zero_step ? psv_pkg::B_ROWS : psv_pkg::B_TAN;
      psv_pkg::B_TAN:   if (tan_rsp.done) st_nxt = psv_pkg::B_ROWS;
      psv_pkg::B_ROWS:  if (en && row_done && last_row) st_nxt = psv_pkg::B_DRAIN;
      psv_pkg::B_DRAIN: if (!s1_v_r && !s2_v_r) st_nxt = psv_pkg::B_IDLE;
      default:          st_nxt = psv_pkg::B_IDLE;
    endcase
  end

  // path and surface state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      have_prev_r  <= 1'b0;
      org_known_r  <= 1'b0;
      first_pend_r <= 1'b0;
      tx_r         <= psv_pkg::Q15_ONE;
      ty_r         <= '0;
      row_r        <= '0;
      col_r        <= '0;
      two_rows_r   <= 1'b0;
      on_first_r   <= 1'b0;
    end else begin
      if (take) begin
        unique case (q_item.act)
          psv_pkg::ACT_CLEAR: begin
            cnt_r        <= '0;
            prev_x_r     <= '0;
            prev_y_r     <= '0;
            org_x_r      <= '0;
            org_y_r      <= '0;
            have_prev_r  <= 1'b0;
            org_known_r  <= 1'b0;
            first_pend_r <= 1'b0;
            tx_r         <= psv_pkg::Q15_ONE;
            ty_r         <= '0;
            row_r        <= '0;
          end
          psv_pkg::ACT_LOAD: begin
            if (cnt_r < NW'(PROFILE_MAX)) cnt_r <= cnt_r + NW'(1);
          end
          psv_pkg::ACT_SEED: begin
            if (!org_known_r) begin
              prev_x_r    <= q_item.x;
              prev_y_r    <= q_item.y;
              have_prev_r <= 1'b1;
            end
          end
          psv_pkg::ACT_PATH: begin
            org_x_r     <= org_x_n;
            org_y_r     <= org_y_n;
            org_known_r <= 1'b1;
            if (have_prev_r) begin
              two_rows_r   <= first_pend_r;
              on_first_r   <= first_pend_r;
              first_pend_r <= 1'b0;
              col_r        <= '0;
            end else begin
              first_pend_r <= 1'b1;
              have_prev_r  <= 1'b1;
            end
            prev_x_r <= q_item.x;
            prev_y_r <= q_item.y;
          end
          default: ;
        endcase
      end
      if ((st_r == psv_pkg::B_TAN) && tan_rsp.done) begin
        tx_r <= tan_rsp.tx;
        ty_r <= tan_rsp.ty;
      end
      if ((st_r == psv_pkg::B_ROWS) && en) begin
        if (row_done) begin
          row_r <= row_r + 16'd1;
          col_r <= '0;
          if (!last_row) on_first_r <= 1'b0;
        end else begin
          col_r <= col_r + IW'(1);
        end
      end
    end
  end

  // row offsets relative to the origin
  always_ff @(posedge clk) begin
    if (is_path_go) begin
      bp_x_r <= {prev_x_r[31], prev_x_r} - {org_x_n[31], org_x_n};
      bp_y_r <= {prev_y_r[31], prev_y_r} - {org_y_n[31], org_y_n};
      bc_x_r <= {q_item.x[31], q_item.x} - {org_x_n[31], org_x_n};
      bc_y_r <= {q_item.y[31], q_item.y} - {org_y_n[31], org_y_n};
    end
  end

  // profile store
  always_ff @(posedge clk) begin
    if (take && (q_item.act == psv_pkg::ACT_LOAD) && (cnt_r < NW'(PROFILE_MAX))) begin
      store_x[cnt_r[IW-1:0]] <= q_item.x;
      store_y[cnt_r[IW-1:0]] <= q_item.y;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_rx_r <= store_x[col_r];
      s1_ry_r <= store_y[col_r];
      s1_m_r  <= meta_in;
    end
  end

  // pipeline control: all stages move together when the output can load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pty_r  <= s1_rx_r * ty_r;
      ptx_r  <= s1_rx_r * tx_r;
      s2_z_r <= s1_ry_r;
      s2_m_r <= s1_m_r;
    end
  end

  // round Q17.31 to Q16.16 (floor after adding half) and offset
  always_comb begin
    rnd_x = 49'(pty_r) + 49'sd16384;
    rnd_y = 49'sd16384 - 49'(ptx_r);
    shx   = rnd_x >>> 15;
    shy   = rnd_y >>> 15;
    sum_x = {{2{s2_m_r.bx[32]}}, s2_m_r.bx} + shx[34:0];
    sum_y = {{2{s2_m_r.by[32]}}, s2_m_r.by} + shy[34:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r    <= sat35(sum_x);
      oy_r    <= sat35(sum_y);
      oz_r    <= s2_z_r;
      orow_r  <= s2_m_r.row;
      ocol_r  <= s2_m_r.col;
      olast_r <= s2_m_r.last;
    end
  end

  assign out_valid         = out_v_r;
  assign out_vertex_x      = ox_r;
  assign out_vertex_y      = oy_r;
  assign out_vertex_z      = oz_r;
  assign out_row_number    = orow_r;
  assign out_column_number = ocol_r;
  assign out_last_of_run   = olast_r;

endmodule

### src/profile_sweep_vertex_gen.sv
// ----------------------------------------------------------------------------
// profile_sweep_vertex_gen
// Sweeps a stored 2D profile along a streamed 2D path, one vertex per
// profile point per path row.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+------------
//  in_     | input     | action, point_x, point_y                  | valid/stall
//  out_    | output    | vertex_x/y/z, row_number, column_number,  | valid/stall
//          |           | last_of_run                               |
//
//  Clear, load and seed are each taken by the back end while it is idle.
//  A path point with a nonzero step runs the tangent unit (squares, 32-step
//  square root, 17-step dividers), then emits one vertex per cycle while out_
//  is not stalled (count, or twice count for the pending first row), then
//  waits for the vertex pipeline to drain. A zero step skips the tangent.
//  Reset (rst_n low, synchronous) empties the queue and the pipeline;
//  the profile store itself is not cleared.
//  A stall on out_ freezes the whole vertex pipeline; the two-entry input
//  queue keeps accepting until it fills.
//
module profile_sweep_vertex_gen #(
  parameter int PROFILE_MAX = psv_pkg::PROFILE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z,
  output logic [15:0]        out_row_number,
  output logic [4:0]         out_column_number,
  output logic               out_last_of_run
);

  logic              q_valid;
  logic              q_pop;
  psv_pkg::item_t    q_item;
  psv_pkg::tan_req_t tan_req;
  psv_pkg::tan_rsp_t tan_rsp;

  // front: decode and queue incoming transfers
  psv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // multi-cycle tangent normalizer used by the back end
  psv_tangent u_tangent (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tan_req),
    .rsp   (tan_rsp)
  );

  // back: state update, profile store and vertex pipeline
  psv_back #(
    .PROFILE_MAX (PROFILE_MAX)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .tan_req           (tan_req),
    .tan_rsp           (tan_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_vertex_z      (out_vertex_z),
    .out_row_number    (out_row_number),
    .out_column_number (out_column_number),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

### src/psv_checker.sv
// ----------------------------------------------------------------------------
// psv_checker
// Port-level checks on the vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "profile_sweep_vertex_gen_assert.svh"

module psv_checker #(
  parameter int PROFILE_MAX = psv_pkg::PROFILE_MAX_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_vertex_x,
  input logic [31:0] out_vertex_y,
  input logic [4:0]  out_column_number,
  input logic        out_last_of_run
);

  `PSV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_vertex_x) && $stable(out_vertex_y) && $stable(out_last_of_run), "stalled vertex changed")

  `PSV_ASSERT(a_col_range, out_valid |-> ($unsigned(out_column_number) < PROFILE_MAX), "column beyond profile store")

  `PSV_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

endmodule

bind profile_sweep_vertex_gen psv_checker #(
  .PROFILE_MAX (PROFILE_MAX)
) u_psv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_vertex_x      (out_vertex_x),
  .out_vertex_y      (out_vertex_y),
  .out_column_number (out_column_number),
  .out_last_of_run   (out_last_of_run)
);
